[rtl/rotation_matrix_to_quaternion_core_defines.svh]
// Assertion macros used by the converter top level.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH

// Clocked property, disabled while reset is asserted (active low).
`define RMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the macro above.
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `RMQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/rmq_pkg.sv]
// Shared widths, types and codes for the rotation-to-quaternion converter.
package rmq_pkg;

    localparam int FRAC_BITS = 30;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int TR_W      = IN_W + 2;                  // sum of three elements
    localparam int NUM_W     = IN_W + 1;                  // sum/diff of two elements
    localparam int MAG_W     = NUM_W;                     // magnitude of a numerator
    localparam int U_W       = IN_W + 3;                  // radicand before the shift
    localparam int U_MAG_W   = IN_W + 1;                  // positive radicand bits
    localparam int X_W       = U_MAG_W + FRAC_BITS - 2;   // shifted radicand
    localparam int SQ_STEPS  = (X_W + 1) / 2;
    localparam int X2_W      = 2 * SQ_STEPS;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int SREM_W    = ROOT_W + 3;
    localparam int DIAG_W    = ROOT_W + 1;
    localparam int DEN_W     = DIAG_W + 2;
    localparam int N_W       = MAG_W + FRAC_BITS;         // dividend
    localparam int Q_W       = OUT_W;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_LAT   = DIV_STEPS + 4;             // prep x3, bit steps, output

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } case_t;

    // Sideband carried alongside the square root.
    typedef struct packed {
        case_t                      sel;
        logic [3:0][NUM_W-1:0]      num;
    } sq_side_t;

endpackage

[rtl/rotation_matrix_to_quaternion_core.sv]
// Top level: rotation matrix (Q2.30) to quaternion, Shepperd branch form, fully pipelined.
//
//  channel | dir | tdata                               | tuser
//  s_      | in  | r00,r01,r02,r10,r11,r12,r20,r21,r22 | -
//  m_      | out | quat_w,quat_x,quat_y,quat_z          | case_taken
//
// One request is taken per cycle while the output is not stalled; the square root
// and divider lanes are bit-per-stage pipelines.
// Reset (aresetn, synchronous) clears only the stage valid bits.
// A stalled output holds every stage; nothing is lost or repeated.
`include "rotation_matrix_to_quaternion_core_defines.svh"
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [287:0]   s_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22, 32 bits each
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,   // quat_w,quat_x,quat_y,quat_z, 32 bits each
    output logic [1:0]     m_tuser    // case_taken
);

    logic adv;

    // stage 1: input register
    logic                   s1_valid_reg;
    logic signed [IN_W-1:0] s1_r_reg [9];
    // stage 2: trace and diagonal compares
    logic                   s2_valid_reg;
    logic signed [IN_W-1:0] s2_r_reg [9];
    logic signed [TR_W-1:0] s2_trace_reg;
    logic                   s2_gt01_reg, s2_gt02_reg, s2_gt12_reg;
    // stage 3: case, radicand, numerators
    logic                   s3_valid_reg;
    logic [X2_W-1:0]        s3_x_reg;
    sq_side_t               s3_side_reg;

    case_t                  sel_c;
    logic signed [U_W-1:0]  u_c;
    logic [3:0][NUM_W-1:0]  num_c;
    logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, a01_10, a02_20, a12_21;

    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    logic [SREM_W-1:0]      sq_rem;
    sq_side_t               sq_side;

    // rounding stage
    logic                   rd_valid_reg;
    logic [DIAG_W-1:0]      rd_diag_reg;
    sq_side_t               rd_side_reg;

    // delay line beside the divider lanes
    logic                   dl_valid_reg [DIV_LAT];
    logic [DIAG_W-1:0]      dl_diag_reg  [DIV_LAT];
    case_t                  dl_sel_reg   [DIV_LAT];

    logic signed [Q_W-1:0]  lane_q [4];

    // output register
    logic                   m_valid_reg;
    logic [3:0][OUT_W-1:0]  m_quat_reg;
    case_t                  m_case_reg;

    // whole pipe advances when the output register is free or being drained
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // numerators per Shepperd's method
    assign d21_12 = NUM_W'(s2_r_reg[7]) - NUM_W'(s2_r_reg[5]);
    assign d02_20 = NUM_W'(s2_r_reg[2]) - NUM_W'(s2_r_reg[6]);
    assign d10_01 = NUM_W'(s2_r_reg[3]) - NUM_W'(s2_r_reg[1]);
    assign a01_10 = NUM_W'(s2_r_reg[1]) + NUM_W'(s2_r_reg[3]);
    assign a02_20 = NUM_W'(s2_r_reg[2]) + NUM_W'(s2_r_reg[6]);
    assign a12_21 = NUM_W'(s2_r_reg[5]) + NUM_W'(s2_r_reg[7]);

    // case selection
    always_comb begin
        priority if (!s2_trace_reg[TR_W-1] && s2_trace_reg != '0) begin
            sel_c = CASE_TRACE;
        end else if (s2_gt01_reg && s2_gt02_reg) begin
            sel_c = CASE_X;
        end else if (s2_gt12_reg) begin
            sel_c = CASE_Y;
        end else begin
            sel_c = CASE_Z;
        end
    end

    // radicand and numerator routing
    always_comb begin
        unique case (sel_c)
            CASE_TRACE: begin
                u_c   = U_W'(1 << FRAC_BITS) + U_W'(s2_trace_reg);
                num_c = {d10_01, d02_20, d21_12, NUM_W'(0)};
            end
            CASE_X: begin
                u_c   = U_W'(1 << FRAC_BITS) + U_W'(s2_r_reg[0])
                      - U_W'(s2_r_reg[4]) - U_W'(s2_r_reg[8]);
                num_c = {a02_20, a01_10, NUM_W'(0), d21_12};
            end
            CASE_Y: begin
                u_c   = U_W'(1 << FRAC_BITS) + U_W'(s2_r_reg[4])
                      - U_W'(s2_r_reg[0]) - U_W'(s2_r_reg[8]);
                num_c = {a12_21, NUM_W'(0), a01_10, d02_20};
            end
            default: begin
                u_c   = U_W'(1 << FRAC_BITS) + U_W'(s2_r_reg[8])
                      - U_W'(s2_r_reg[0]) - U_W'(s2_r_reg[4]);
                num_c = {NUM_W'(0), a12_21, a02_20, d10_01};
            end
        endcase
    end

    // front valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            rd_valid_reg <= sq_valid;
        end
    end

    // front payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                s1_r_reg[k] <= $signed(s_tdata[k*IN_W +: IN_W]);
                s2_r_reg[k] <= s1_r_reg[k];
            end
            s2_trace_reg <= TR_W'(s1_r_reg[0]) + TR_W'(s1_r_reg[4]) + TR_W'(s1_r_reg[8]);
            s2_gt01_reg  <= s1_r_reg[0] > s1_r_reg[4];
            s2_gt02_reg  <= s1_r_reg[0] > s1_r_reg[8];
            s2_gt12_reg  <= s1_r_reg[4] > s1_r_reg[8];

            // non-positive radicand gives a zero root
            if (!u_c[U_W-1] && u_c != '0) begin
                s3_x_reg <= X2_W'(u_c[U_MAG_W-1:0]) << (FRAC_BITS - 2);
            end else begin
                s3_x_reg <= '0;
            end
            s3_side_reg.sel <= sel_c;
            s3_side_reg.num <= num_c;

            // round root to nearest
            rd_diag_reg <= (SREM_W'(sq_root) < sq_rem) ? DIAG_W'(sq_root) + DIAG_W'(1)
                                                       : DIAG_W'(sq_root);
            rd_side_reg <= sq_side;
        end
    end

    rmq_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .in_x      (s3_x_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_rem   (sq_rem),
        .out_side  (sq_side)
    );

    // four divider lanes by 4*diag
    for (genvar k = 0; k < 4; k++) begin : g_lane
        rmq_div_pipe u_div (
            .aclk   (aclk),
            .en     (adv),
            .in_num ($signed(rd_side_reg.num[k])),
            .in_den ({rd_diag_reg, 2'b00}),
            .out_q  (lane_q[k])
        );
    end

    // delay line valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) dl_valid_reg[i] <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            for (int i = 0; i < DIV_LAT; i++)
                dl_valid_reg[i] <= (i == 0) ? rd_valid_reg : dl_valid_reg[(i == 0) ? 0 : i - 1];
            m_valid_reg <= dl_valid_reg[DIV_LAT-1];
        end
    end

    // delay line payload and output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                dl_diag_reg[i] <= (i == 0) ? rd_diag_reg : dl_diag_reg[(i == 0) ? 0 : i - 1];
                dl_sel_reg[i]  <= (i == 0) ? rd_side_reg.sel : dl_sel_reg[(i == 0) ? 0 : i - 1];
            end
            for (int k = 0; k < 4; k++) begin
                m_quat_reg[k] <= (case_t'(k) == dl_sel_reg[DIV_LAT-1])
                               ? OUT_W'(dl_diag_reg[DIV_LAT-1]) : OUT_W'(lane_q[k]);
            end
            m_case_reg <= dl_sel_reg[DIV_LAT-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_quat_reg;
    assign m_tuser  = m_case_reg;

    // checks
    `RMQ_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_tvalid && s_tready, s1_valid_reg,
        "accepted request did not enter stage 1")
    `RMQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !adv,
        $stable(rd_valid_reg) && $stable(s3_valid_reg) && $stable(m_valid_reg),
        "pipeline moved during a stall")
    `RMQ_ASSERT(a_diag_range, aclk, aresetn,
        !rd_valid_reg || !rd_diag_reg[DIAG_W-1], "rounded root exceeds 31 bits")
    `RMQ_ASSERT(a_diag_nonneg, aclk, aresetn,
        !m_valid_reg || !m_quat_reg[m_case_reg][OUT_W-1],
        "selected component is negative")

endmodule

[rtl/rmq_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, with sideband.
module rmq_sqrt_pipe
    import rmq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [X2_W-1:0]   in_x,
    input  sq_side_t          in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SREM_W-1:0] out_rem,
    output sq_side_t          out_side
);

    logic              valid_reg [SQ_STEPS];
    logic [X2_W-1:0]   x_reg     [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg  [SQ_STEPS];
    logic [SREM_W-1:0] rem_reg   [SQ_STEPS];
    sq_side_t          side_reg  [SQ_STEPS];

    logic [X2_W-1:0]   x_next    [SQ_STEPS];
    logic [ROOT_W-1:0] root_next [SQ_STEPS];
    logic [SREM_W-1:0] rem_next  [SQ_STEPS];
    logic [X2_W-1:0]   src_x     [SQ_STEPS];
    logic [ROOT_W-1:0] src_root  [SQ_STEPS];
    logic [SREM_W-1:0] src_rem   [SQ_STEPS];
    logic [SREM_W-1:0] acc       [SQ_STEPS];
    logic [SREM_W-1:0] trial     [SQ_STEPS];

    // one digit per stage: bring down two radicand bits, try root*4+1
    always_comb begin
        for (int i = 0; i < SQ_STEPS; i++) begin
            src_x[i]    = (i == 0) ? in_x : x_reg[(i == 0) ? 0 : i - 1];
            src_root[i] = (i == 0) ? '0   : root_reg[(i == 0) ? 0 : i - 1];
            src_rem[i]  = (i == 0) ? '0   : rem_reg[(i == 0) ? 0 : i - 1];
            acc[i]      = {src_rem[i][SREM_W-3:0], src_x[i][X2_W-1 -: 2]};
            trial[i]    = SREM_W'({src_root[i], 2'b01});
            x_next[i]   = src_x[i] << 2;
            if (acc[i] >= trial[i]) begin
                rem_next[i]  = acc[i] - trial[i];
                root_next[i] = {src_root[i][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[i]  = acc[i];
                root_next[i] = {src_root[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_STEPS; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < SQ_STEPS; i++)
                valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQ_STEPS; i++) begin
                x_reg[i]    <= x_next[i];
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];
    assign out_rem   = rem_reg[SQ_STEPS-1];
    assign out_side  = side_reg[SQ_STEPS-1];

endmodule

[rtl/rmq_div_pipe.sv]
// One divider lane: round(num * 2^FRAC_BITS / den), saturated, one quotient bit per stage.
module rmq_div_pipe
    import rmq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] in_num,
    input  logic        [DEN_W-1:0] in_den,
    output logic signed [Q_W-1:0]   out_q
);

    // prep stage 1: sign and magnitude
    logic             p1_neg_reg;
    logic [MAG_W-1:0] p1_mag_reg;
    logic [DEN_W-1:0] p1_den_reg;
    // prep stage 2: dividend with rounding half added
    logic             p2_neg_reg;
    logic [N_W-1:0]   p2_n_reg;
    logic [DEN_W-1:0] p2_den_reg;
    // prep stage 3: overflow and zero flags
    logic             p3_neg_reg;
    logic             p3_sat_reg;
    logic             p3_zero_reg;
    logic [N_W-1:0]   p3_n_reg;
    logic [DEN_W-1:0] p3_den_reg;

    logic             st_neg_reg  [DIV_STEPS];
    logic             st_sat_reg  [DIV_STEPS];
    logic             st_zero_reg [DIV_STEPS];
    logic [Q_W-1:0]   st_low_reg  [DIV_STEPS];
    logic [Q_W-1:0]   st_q_reg    [DIV_STEPS];
    logic [DEN_W-1:0] st_rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0] st_den_reg  [DIV_STEPS];

    logic [Q_W-1:0]   src_low  [DIV_STEPS];
    logic [Q_W-1:0]   src_q    [DIV_STEPS];
    logic [DEN_W-1:0] src_rem  [DIV_STEPS];
    logic [DEN_W-1:0] src_den  [DIV_STEPS];
    logic [DEN_W:0]   acc      [DIV_STEPS];
    logic [DEN_W-1:0] rem_next [DIV_STEPS];
    logic [Q_W-1:0]   q_next   [DIV_STEPS];

    logic [Q_W-1:0]   q_lim;
    logic [Q_W-1:0]   q_mag;
    logic signed [Q_W-1:0] q_next_out;

    localparam logic [Q_W-1:0] Q_HALF = Q_W'(1) << (Q_W - 1);

    // restoring division bit steps
    always_comb begin
        for (int i = 0; i < DIV_STEPS; i++) begin
            src_low[i] = (i == 0) ? p3_n_reg[Q_W-1:0] : st_low_reg[(i == 0) ? 0 : i - 1];
            src_q[i]   = (i == 0) ? '0 : st_q_reg[(i == 0) ? 0 : i - 1];
            src_rem[i] = (i == 0) ? DEN_W'(p3_n_reg[N_W-1:Q_W])
                                  : st_rem_reg[(i == 0) ? 0 : i - 1];
            src_den[i] = (i == 0) ? p3_den_reg : st_den_reg[(i == 0) ? 0 : i - 1];
            acc[i]     = {src_rem[i], src_low[i][Q_W-1]};
            if (acc[i] >= {1'b0, src_den[i]}) begin
                rem_next[i] = DEN_W'(acc[i] - {1'b0, src_den[i]});
                q_next[i]   = {src_q[i][Q_W-2:0], 1'b1};
            end else begin
                rem_next[i] = DEN_W'(acc[i]);
                q_next[i]   = {src_q[i][Q_W-2:0], 1'b0};
            end
        end
    end

    // clamp to 2^31 magnitude, apply sign, saturate the positive end
    always_comb begin
        q_mag = st_q_reg[DIV_STEPS-1];
        if (st_sat_reg[DIV_STEPS-1] || q_mag > Q_HALF) begin
            q_lim = Q_HALF;
        end else begin
            q_lim = q_mag;
        end
        if (st_zero_reg[DIV_STEPS-1]) begin
            q_next_out = '0;
        end else if (st_neg_reg[DIV_STEPS-1]) begin
            q_next_out = $signed(-q_lim);
        end else if (q_lim == Q_HALF) begin
            q_next_out = $signed(Q_HALF - Q_W'(1));
        end else begin
            q_next_out = $signed(q_lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_neg_reg  <= in_num[NUM_W-1];
            p1_mag_reg  <= in_num[NUM_W-1] ? MAG_W'(-in_num) : MAG_W'(in_num);
            p1_den_reg  <= in_den;

            p2_neg_reg  <= p1_neg_reg;
            p2_n_reg    <= (N_W'(p1_mag_reg) << FRAC_BITS) + N_W'(p1_den_reg >> 1);
            p2_den_reg  <= p1_den_reg;

            p3_neg_reg  <= p2_neg_reg;
            p3_sat_reg  <= DEN_W'(p2_n_reg[N_W-1:Q_W]) >= p2_den_reg;
            p3_zero_reg <= (p2_den_reg == '0);
            p3_n_reg    <= p2_n_reg;
            p3_den_reg  <= p2_den_reg;

            for (int i = 0; i < DIV_STEPS; i++) begin
                st_neg_reg[i]  <= (i == 0) ? p3_neg_reg  : st_neg_reg[(i == 0) ? 0 : i - 1];
                st_sat_reg[i]  <= (i == 0) ? p3_sat_reg  : st_sat_reg[(i == 0) ? 0 : i - 1];
                st_zero_reg[i] <= (i == 0) ? p3_zero_reg : st_zero_reg[(i == 0) ? 0 : i - 1];
                st_low_reg[i]  <= src_low[i] << 1;
                st_q_reg[i]    <= q_next[i];
                st_rem_reg[i]  <= rem_next[i];
                st_den_reg[i]  <= src_den[i];
            end

            out_q <= q_next_out;
        end
    end

endmodule
